[src/tch_pkg.sv]
`default_nettype none
package tch_pkg;

   // axis select codes
   localparam logic [2:0] AXIS_X_POS = 3'd0;
   localparam logic [2:0] AXIS_X_NEG = 3'd1;
   localparam logic [2:0] AXIS_Y_POS = 3'd2;
   localparam logic [2:0] AXIS_Y_NEG = 3'd3;
   localparam logic [2:0] AXIS_Z_POS = 3'd4;
   localparam logic [2:0] AXIS_Z_NEG = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_FORWARD = 2'd0;
   localparam logic [1:0] CSR_RIGHT   = 2'd1;
   localparam logic [1:0] CSR_UP      = 2'd2;

   localparam int ATAN_LEN = 24;
   localparam int ROT_W    = 19;  // Q16 sine and cosine path
   localparam int PROD_W   = 38;  // products and horizontal components
   localparam int VEC_W    = 40;  // vectoring path
   localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 19'sd39797;

   // atan(2^-i) in turns, scaled by 2^32
   function automatic logic [31:0] atan_turn32(input int i);
      logic [31:0] t;
      unique case (i)
         0:  t = 32'd536870912;
         1:  t = 32'd316933406;
         2:  t = 32'd167458907;
         3:  t = 32'd85004756;
         4:  t = 32'd42667331;
         5:  t = 32'd21354465;
         6:  t = 32'd10679838;
         7:  t = 32'd5340245;
         8:  t = 32'd2670163;
         9:  t = 32'd1335087;
         10: t = 32'd667544;
         11: t = 32'd333772;
         12: t = 32'd166886;
         13: t = 32'd83443;
         14: t = 32'd41722;
         15: t = 32'd20861;
         16: t = 32'd10430;
         17: t = 32'd5215;
         18: t = 32'd2608;
         19: t = 32'd1304;
         20: t = 32'd652;
         21: t = 32'd326;
         22: t = 32'd163;
         23: t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

[src/tch_cordic_cell.sv]
`default_nettype none
module tch_cordic_cell #(
   parameter int W      = 19,
   parameter int AB     = 16,
   parameter int IDX    = 0,
   parameter bit ROTATE = 1'b1
) (
   input  wire                      clock,
   input  wire                      load,
   input  wire logic signed [W-1:0] x_in,
   input  wire logic signed [W-1:0] y_in,
   input  wire logic signed [AB:0]  z_in,
   output logic signed [W-1:0]      x_out,
   output logic signed [W-1:0]      y_out,
   output logic signed [AB:0]       z_out
);
   localparam int          SH  = 32 - AB;
   localparam logic [31:0] TRN = tch_pkg::atan_turn32(IDX);
   localparam logic [32:0] ENT = ({1'b0, TRN} + (33'd1 << (SH - 1))) >> SH;
   localparam logic signed [AB:0] STEP = ENT[AB:0];

   logic signed [W-1:0] x_ff, x_in_n;
   logic signed [W-1:0] y_ff, y_in_n;
   logic signed [AB:0]  z_ff, z_in_n;
   logic signed [W-1:0] dx, dy;
   logic                pos;

   always_comb begin
      dx  = y_in >>> IDX;
      dy  = x_in >>> IDX;
      // rotation follows the residual angle, vectoring drives y toward zero
      pos = ROTATE ? !z_in[AB] : !(y_in > 0);
      if (pos) begin
         x_in_n = x_in - dx;
         y_in_n = y_in + dy;
         z_in_n = z_in - STEP;
      end else begin
         x_in_n = x_in + dx;
         y_in_n = y_in - dy;
         z_in_n = z_in + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

[src/tilt_compensated_heading.sv]
`default_nettype none
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall mag_x, mag_y, mag_z, roll_angle, pitch_angle
// rsp_      out        rsp_valid/rsp_stall heading_angle
// csr_      in         csr_valid/csr_ready csr_index, csr_data
//
// One item per cycle unless rsp_stall backs the pipeline up; the path runs through the two rows
// of CORDIC cells (sine/cosine, then arctangent) and the multiply/add stages.
// Reset is synchronous; it empties the pipeline and restores the axis selects.
// Each stage advances when its successor is free, so bubbles close up and the
// input keeps flowing while a result waits on rsp_stall, until the pipeline fills.
module tilt_compensated_heading #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire logic signed [15:0] req_mag_x,
   input  wire logic signed [15:0] req_mag_y,
   input  wire logic signed [15:0] req_mag_z,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [15:0]       rsp_heading_angle,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [2:0]   csr_data
);
   localparam int AB = ANGLE_BITS;
   localparam int N  = CORDIC_STAGES;
   localparam int RW = tch_pkg::ROT_W;
   localparam int PW = tch_pkg::PROD_W;
   localparam int VW = tch_pkg::VEC_W;
   localparam int SM1 = N + 1;
   localparam int SM2 = N + 2;
   localparam int SM3 = N + 3;
   localparam int SM4 = N + 4;
   localparam int SPR = N + 5;
   localparam int L   = 2 * N + 6;
   localparam logic [AB-1:0] HALF = {1'b1, {(AB-1){1'b0}}};

   // configuration
   logic [2:0] fwd_sel_ff, right_sel_ff, up_sel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff   <= tch_pkg::AXIS_X_POS;
         right_sel_ff <= tch_pkg::AXIS_Y_POS;
         up_sel_ff    <= tch_pkg::AXIS_Z_POS;
      end else if (csr_valid) begin
         unique case (csr_index)
            tch_pkg::CSR_FORWARD: fwd_sel_ff   <= csr_data;
            tch_pkg::CSR_RIGHT:   right_sel_ff <= csr_data;
            tch_pkg::CSR_UP:      up_sel_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // flow control
   logic [L-1:0] v_ff;
   logic [L:0]   go;
   logic         rsp_valid_ff;
   logic [15:0]  rsp_heading_ff, heading_in;

   always_comb begin
      go[L] = !rsp_valid_ff || !rsp_stall;
      for (int k = L - 1; k >= 0; k--) begin
         go[k] = !v_ff[k] || go[k+1];
      end
   end

   assign req_stall = !go[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < L; k++) begin
            if (go[k]) v_ff[k] <= v_ff[k-1];
         end
         if (go[L]) rsp_valid_ff <= v_ff[L-1];
      end
   end

   // input stage: axis remap and angle fold
   function automatic logic signed [15:0] sat_neg(input logic signed [15:0] v);
      return (v == 16'sh8000) ? 16'sh7fff : -v;
   endfunction

   function automatic logic signed [15:0] pick_axis(input logic [2:0] sel,
         input logic signed [15:0] mx, input logic signed [15:0] my,
         input logic signed [15:0] mz);
      logic signed [15:0] r;
      unique case (sel)
         tch_pkg::AXIS_X_POS: r = mx;
         tch_pkg::AXIS_X_NEG: r = sat_neg(mx);
         tch_pkg::AXIS_Y_POS: r = my;
         tch_pkg::AXIS_Y_NEG: r = sat_neg(my);
         tch_pkg::AXIS_Z_POS: r = mz;
         tch_pkg::AXIS_Z_NEG: r = sat_neg(mz);
         default:             r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [AB-1:0] angle_in(input logic [15:0] raw);
      logic [AB-1:0] a;
      if (AB > 16) a = AB'({raw, {(AB > 16 ? AB - 16 : 1){1'b0}}} >> (AB > 16 ? 0 : 1));
      else         a = AB'(raw >> (16 - AB));
      return a;
   endfunction

   // fold second and third quarter-turns onto the first and fourth
   function automatic logic fold_flip(input logic [AB-1:0] a);
      return a[AB-1] ^ a[AB-2];
   endfunction

   function automatic logic signed [AB:0] fold_z(input logic [AB-1:0] a);
      logic [AB-1:0] b;
      b = fold_flip(a) ? a - HALF : a;
      return {b[AB-1], b};
   endfunction

   logic signed [15:0] f_sb [0:N];
   logic signed [15:0] r_sb [0:N];
   logic signed [15:0] u_sb [0:N];
   logic               flr_sb [0:N];
   logic               flp_sb [0:N];
   logic signed [RW-1:0] rx [0:N], ry [0:N], px [0:N], py [0:N];
   logic signed [AB:0]   rz [0:N], pz [0:N];
   logic signed [AB:0]   roll_z_ff, pitch_z_ff;
   logic [AB-1:0]        roll_a, pitch_a;

   assign roll_a  = angle_in(req_roll_angle);
   assign pitch_a = angle_in(req_pitch_angle);

   always_ff @(posedge clock) begin
      if (go[0]) begin
         f_sb[0]    <= pick_axis(fwd_sel_ff, req_mag_x, req_mag_y, req_mag_z);
         r_sb[0]    <= pick_axis(right_sel_ff, req_mag_x, req_mag_y, req_mag_z);
         u_sb[0]    <= pick_axis(up_sel_ff, req_mag_x, req_mag_y, req_mag_z);
         flr_sb[0]  <= fold_flip(roll_a);
         flp_sb[0]  <= fold_flip(pitch_a);
         roll_z_ff  <= fold_z(roll_a);
         pitch_z_ff <= fold_z(pitch_a);
      end
   end

   assign rx[0] = tch_pkg::CORDIC_GAIN;
   assign ry[0] = '0;
   assign rz[0] = roll_z_ff;
   assign px[0] = tch_pkg::CORDIC_GAIN;
   assign py[0] = '0;
   assign pz[0] = pitch_z_ff;

   // sine/cosine row: roll and pitch side by side
   for (genvar i = 0; i < N; i++) begin : g_rot
      tch_cordic_cell #(.W(RW), .AB(AB), .IDX(i), .ROTATE(1'b1)) u_roll (
         .clock(clock), .load(go[i+1]),
         .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]),
         .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1])
      );
      tch_cordic_cell #(.W(RW), .AB(AB), .IDX(i), .ROTATE(1'b1)) u_pitch (
         .clock(clock), .load(go[i+1]),
         .x_in(px[i]), .y_in(py[i]), .z_in(pz[i]),
         .x_out(px[i+1]), .y_out(py[i+1]), .z_out(pz[i+1])
      );
      always_ff @(posedge clock) begin
         if (go[i+1]) begin
            f_sb[i+1]   <= f_sb[i];
            r_sb[i+1]   <= r_sb[i];
            u_sb[i+1]   <= u_sb[i];
            flr_sb[i+1] <= flr_sb[i];
            flp_sb[i+1] <= flp_sb[i];
         end
      end
   end

   // tilt compensation
   logic signed [RW-1:0] cr, sr, cp, sp;
   logic signed [PW-1:0] srsp_p_ff, srcp_p_ff, fcp_ff, usp_ff, rcr_ff;
   logic signed [15:0]   f1_ff, u1_ff, f2_ff, u2_ff;
   logic signed [PW-1:0] srsp_r, srcp_r;
   logic signed [RW-1:0] srsp_ff, srcp_ff;
   logic signed [PW-1:0] xc2_ff, rcr2_ff, xc3_ff, rcr3_ff, fa_ff, ub_ff;
   logic signed [PW-1:0] xc4_ff, yc4_ff;

   always_comb begin
      cr = flr_sb[N] ? -rx[N] : rx[N];
      sr = flr_sb[N] ? -ry[N] : ry[N];
      cp = flp_sb[N] ? -px[N] : px[N];
      sp = flp_sb[N] ? -py[N] : py[N];
      srsp_r = (srsp_p_ff + PW'(32768)) >>> 16;
      srcp_r = (srcp_p_ff + PW'(32768)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (go[SM1]) begin
         srsp_p_ff <= PW'(sr) * PW'(sp);
         srcp_p_ff <= PW'(sr) * PW'(cp);
         fcp_ff    <= PW'(f_sb[N]) * PW'(cp);
         usp_ff    <= PW'(u_sb[N]) * PW'(sp);
         rcr_ff    <= PW'(r_sb[N]) * PW'(cr);
         f1_ff     <= f_sb[N];
         u1_ff     <= u_sb[N];
      end
      if (go[SM2]) begin
         srsp_ff <= srsp_r[RW-1:0];
         srcp_ff <= srcp_r[RW-1:0];
         xc2_ff  <= fcp_ff + usp_ff;
         rcr2_ff <= rcr_ff;
         f2_ff   <= f1_ff;
         u2_ff   <= u1_ff;
      end
      if (go[SM3]) begin
         fa_ff   <= PW'(f2_ff) * PW'(srsp_ff);
         ub_ff   <= PW'(u2_ff) * PW'(srcp_ff);
         xc3_ff  <= xc2_ff;
         rcr3_ff <= rcr2_ff;
      end
      if (go[SM4]) begin
         yc4_ff <= fa_ff + rcr3_ff - ub_ff;
         xc4_ff <= xc3_ff;
      end
   end

   // vectoring setup: move to the right half-plane, note the axis cases
   logic signed [VW-1:0] vx [0:N], vy [0:N];
   logic signed [AB:0]   vz [0:N];
   logic                 yz_sb [0:N];
   logic                 xn_sb [0:N];
   logic signed [VW-1:0] vx0_ff, vy0_ff;
   logic signed [AB:0]   vz0_ff;
   logic                 yz0_ff, xn0_ff;

   always_ff @(posedge clock) begin
      if (go[SPR]) begin
         yz0_ff <= (yc4_ff == '0);
         xn0_ff <= xc4_ff[PW-1];
         vx0_ff <= xc4_ff[PW-1] ? -VW'(xc4_ff) : VW'(xc4_ff);
         vy0_ff <= xc4_ff[PW-1] ? -VW'(yc4_ff) : VW'(yc4_ff);
         vz0_ff <= xc4_ff[PW-1] ? {1'b0, HALF} : '0;
      end
   end

   assign vx[0]    = vx0_ff;
   assign vy[0]    = vy0_ff;
   assign vz[0]    = vz0_ff;
   assign yz_sb[0] = yz0_ff;
   assign xn_sb[0] = xn0_ff;

   // arctangent row
   for (genvar i = 0; i < N; i++) begin : g_vec
      tch_cordic_cell #(.W(VW), .AB(AB), .IDX(i), .ROTATE(1'b0)) u_vec (
         .clock(clock), .load(go[SPR+1+i]),
         .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
         .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1])
      );
      always_ff @(posedge clock) begin
         if (go[SPR+1+i]) begin
            yz_sb[i+1] <= yz_sb[i];
            xn_sb[i+1] <= xn_sb[i];
         end
      end
   end

   // result
   logic [AB-1:0] z_fin;
   logic [AB:0]   z_rnd;

   always_comb begin
      if (yz_sb[N]) z_fin = xn_sb[N] ? HALF : '0;
      else          z_fin = vz[N][AB-1:0];
      z_rnd = '0;
      if (AB > 16) begin
         z_rnd      = {1'b0, z_fin} + ((AB+1)'(1) << (AB > 16 ? AB - 17 : 0));
         heading_in = 16'(z_rnd >> (AB - 16));
      end else begin
         heading_in = 16'({z_fin, 16'd0} >> AB);
      end
   end

   always_ff @(posedge clock) begin
      if (go[L]) rsp_heading_ff <= heading_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_angle = rsp_heading_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (v_ff == '0) && !rsp_valid_ff)
      else $error("pipeline not empty after reset");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v_ff[0] && rsp_valid_ff && rsp_stall)
      else $error("input stalled while pipeline has room");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (v_ff[L-1] && go[L]) |=> rsp_valid_ff)
      else $error("finished item lost at output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[L-1] && !go[L]) |=> v_ff[L-1])
      else $error("last stage dropped while blocked");
`endif
endmodule
`default_nettype wire
